// ===== rtl/tkot_pkg.sv =====
// Shared constants and the control type for the top-k occurrence tracker.
package tkot_pkg;

    localparam int LIST_DEPTH_DEF = 11;
    localparam int ID_BITS_DEF    = 20;
    localparam int COUNT_BITS_DEF = 16;

    typedef struct packed {
        logic lookup;
        logic bubble;
        logic miss;
        logic full;
    } tkot_ctrl_t;

endpackage

// ===== rtl/tkot_cell.sv =====
// One list cell: holds an (id, count) entry, matches, inserts and swaps with its neighbours.
module tkot_cell
    import tkot_pkg::*;
#(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FILL_W     = 4,
    parameter int INDEX      = 0,
    parameter bit LAST       = 1'b0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tkot_ctrl_t            ctrl,
    input  logic [ID_BITS-1:0]    key,
    input  logic [FILL_W-1:0]     fill,
    input  logic [ID_BITS-1:0]    above_id,
    input  logic [COUNT_BITS-1:0] above_count,
    input  logic                  swap_above,
    input  logic [ID_BITS-1:0]    below_id,
    input  logic [COUNT_BITS-1:0] below_count,
    input  logic                  below_mark,
    output logic [ID_BITS-1:0]    id,
    output logic [COUNT_BITS-1:0] count,
    output logic                  mark,
    output logic                  hit,
    output logic                  swap
);

    logic [ID_BITS-1:0]    id_reg;
    logic [ID_BITS-1:0]    id_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  mark_reg;
    logic                  mark_next;
    logic                  valid;
    logic                  insert;
    logic [COUNT_BITS-1:0] count_inc;

    assign valid     = fill > FILL_W'(INDEX);
    assign hit       = valid && (id_reg == key);
    assign insert    = ctrl.miss && (ctrl.full ? LAST : (fill == FILL_W'(INDEX)));
    assign swap      = ctrl.bubble && below_mark && (count_reg < below_count);
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        id_next    = id_reg;
        count_next = count_reg;
        mark_next  = mark_reg;
        if (ctrl.lookup)
        begin
            mark_next = hit || insert;
            if (hit)
            begin
                count_next = count_inc;
            end
            else if (insert)
            begin
                id_next    = key;
                count_next = COUNT_BITS'(1);
            end
        end
        else if (swap)
        begin
            id_next    = below_id;
            count_next = below_count;
            mark_next  = 1'b1;
        end
        else if (swap_above)
        begin
            id_next    = above_id;
            count_next = above_count;
            mark_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        count_reg <= count_next;
    end

    assign id    = id_reg;
    assign count = count_reg;
    assign mark  = mark_reg;

endmodule

// ===== rtl/top_k_occurrence_tracker_core.sv =====
// Top level of the top-k occurrence tracker: sequencer, fill count and result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  input    | in_valid/in_ready  | item_id
//  output   | out_valid/out_ready| rank, tally, was_new, evicted, evicted_id, fill
//
//  An item is accepted in IDLE, matched across all cells in LOOKUP, and in BUBBLE the
//  tallied entry climbs p places (at most LIST_DEPTH - 1), one swap between neighbouring
//  cells per place, before the result is loaded into the output register.
//  No new item is taken until the result of the last one is loaded.
//  Reset empties the list at once; no clearing pass.
//  A new item is taken while the previous result waits; a result that finds the
//  output register still full holds the block until out_ready.
module top_k_occurrence_tracker_core
    import tkot_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int RANK_W     = $clog2(LIST_DEPTH),
    parameter int FILL_W     = $clog2(LIST_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ID_BITS-1:0]    item_id,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RANK_W-1:0]     rank,
    output logic [COUNT_BITS-1:0] tally,
    output logic                  was_new,
    output logic                  evicted,
    output logic [ID_BITS-1:0]    evicted_id,
    output logic [FILL_W-1:0]     fill
);

    typedef enum logic [1:0] {
        IDLE,
        LOOKUP,
        BUBBLE
    } state_t;

    state_t                state_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic                  new_reg;
    logic                  evict_reg;
    logic [ID_BITS-1:0]    evict_id_reg;
    logic                  out_valid_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [COUNT_BITS-1:0] tally_reg;
    logic                  was_new_reg;
    logic                  evicted_reg;
    logic [ID_BITS-1:0]    evicted_id_reg;
    logic [FILL_W-1:0]     fill_out_reg;

    tkot_ctrl_t            ctrl;
    logic [ID_BITS-1:0]    cell_id    [LIST_DEPTH];
    logic [COUNT_BITS-1:0] cell_count [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] mark_vec;
    logic [LIST_DEPTH-1:0] hit_vec;
    logic [LIST_DEPTH-1:0] swap_vec;
    logic                  full;
    logic                  settled;
    logic                  emit;
    logic [RANK_W-1:0]     rank_enc;
    logic [COUNT_BITS-1:0] tally_sel;

    assign full        = fill_reg == FILL_W'(LIST_DEPTH);
    assign ctrl.lookup = state_reg == LOOKUP;
    assign ctrl.bubble = state_reg == BUBBLE;
    assign ctrl.miss   = ~|hit_vec;
    assign ctrl.full   = full;
    assign settled     = ~|swap_vec;
    assign emit        = (state_reg == BUBBLE) && settled && (!out_valid_reg || out_ready);

    genvar j;
    generate
        for (j = 0; j < LIST_DEPTH; j++)
        begin : g_cell
            logic [ID_BITS-1:0]    a_id;
            logic [COUNT_BITS-1:0] a_count;
            logic                  a_swap;
            logic [ID_BITS-1:0]    b_id;
            logic [COUNT_BITS-1:0] b_count;
            logic                  b_mark;

            if (j == 0)
            begin : g_head
                assign a_id    = '0;
                assign a_count = '0;
                assign a_swap  = 1'b0;
            end
            else
            begin : g_mid
                assign a_id    = cell_id[j-1];
                assign a_count = cell_count[j-1];
                assign a_swap  = swap_vec[j-1];
            end

            if (j == LIST_DEPTH - 1)
            begin : g_tail
                assign b_id    = '0;
                assign b_count = '0;
                assign b_mark  = 1'b0;
            end
            else
            begin : g_inner
                assign b_id    = cell_id[j+1];
                assign b_count = cell_count[j+1];
                assign b_mark  = mark_vec[j+1];
            end

            tkot_cell #(
                .ID_BITS    (ID_BITS),
                .COUNT_BITS (COUNT_BITS),
                .FILL_W     (FILL_W),
                .INDEX      (j),
                .LAST       (j == LIST_DEPTH - 1)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key         (id_reg),
                .fill        (fill_reg),
                .above_id    (a_id),
                .above_count (a_count),
                .swap_above  (a_swap),
                .below_id    (b_id),
                .below_count (b_count),
                .below_mark  (b_mark),
                .id          (cell_id[j]),
                .count       (cell_count[j]),
                .mark        (mark_vec[j]),
                .hit         (hit_vec[j]),
                .swap        (swap_vec[j])
            );
        end
    endgenerate

    always_comb
    begin
        rank_enc  = '0;
        tally_sel = '0;
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            if (mark_vec[k])
            begin
                rank_enc  = rank_enc | RANK_W'(k);
                tally_sel = tally_sel | cell_count[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            id_reg         <= '0;
            fill_reg       <= '0;
            new_reg        <= 1'b0;
            evict_reg      <= 1'b0;
            evict_id_reg   <= '0;
            out_valid_reg  <= 1'b0;
            rank_reg       <= '0;
            tally_reg      <= '0;
            was_new_reg    <= 1'b0;
            evicted_reg    <= 1'b0;
            evicted_id_reg <= '0;
            fill_out_reg   <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        id_reg    <= item_id;
                        state_reg <= LOOKUP;
                    end
                end
                LOOKUP:
                begin
                    new_reg      <= ctrl.miss;
                    evict_reg    <= ctrl.miss && full;
                    evict_id_reg <= (ctrl.miss && full) ? cell_id[LIST_DEPTH-1] : '0;
                    if (ctrl.miss && !full)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= BUBBLE;
                end
                BUBBLE:
                begin
                    if (emit)
                    begin
                        rank_reg       <= rank_enc;
                        tally_reg      <= tally_sel;
                        was_new_reg    <= new_reg;
                        evicted_reg    <= evict_reg;
                        evicted_id_reg <= evict_id_reg;
                        fill_out_reg   <= fill_reg;
                        state_reg      <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_ready   = state_reg == IDLE;
    assign out_valid  = out_valid_reg;
    assign rank       = rank_reg;
    assign tally      = tally_reg;
    assign was_new    = was_new_reg;
    assign evicted    = evicted_reg;
    assign evicted_id = evicted_id_reg;
    assign fill       = fill_out_reg;

    a_mark_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(mark_vec))
        else $error("more than one cell marked");

    a_ids_unique: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == LOOKUP |-> $onehot0(hit_vec))
        else $error("id matched in more than one cell");

    a_mark_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == LOOKUP |=> $onehot(mark_vec))
        else $error("lookup left no marked cell");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    a_swap_bubble_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BUBBLE |-> swap_vec == '0)
        else $error("cell swap outside bubble phase");

endmodule

// ===== tb/sv/tb_top_k_occurrence_tracker_core.sv =====
// Testbench for the top-k occurrence tracker core: directed and random tallies against a predictor.
`timescale 1ns / 100ps

module tb_top_k_occurrence_tracker_core;
    import tkot_pkg::*;

    localparam int LIST_DEPTH = LIST_DEPTH_DEF;
    localparam int ID_BITS    = ID_BITS_DEF;
    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int RANK_W     = $clog2(LIST_DEPTH);
    localparam int FILL_W     = $clog2(LIST_DEPTH + 1);
    localparam int HOT_IDS    = 16;

    typedef struct packed {
        logic [RANK_W-1:0]     rank;
        logic [COUNT_BITS-1:0] tally;
        logic                  was_new;
        logic                  evicted;
        logic [ID_BITS-1:0]    evicted_id;
        logic [FILL_W-1:0]     fill;
    } tally_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ID_BITS-1:0]    item_id;
    logic                  out_valid;
    logic                  out_ready;
    logic [RANK_W-1:0]     rank;
    logic [COUNT_BITS-1:0] tally;
    logic                  was_new;
    logic                  evicted;
    logic [ID_BITS-1:0]    evicted_id;
    logic [FILL_W-1:0]     fill;

    logic [ID_BITS-1:0]    list_ids[LIST_DEPTH];
    logic [COUNT_BITS-1:0] list_counts[LIST_DEPTH];
    int                    list_used = 0;
    logic [ID_BITS-1:0]    hot_ids[HOT_IDS];

    tally_result_t expected_tallies[$];
    int            mismatches = 0;
    bit            idle_on = 1'b0;

    top_k_occurrence_tracker_core #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_id    (item_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rank       (rank),
        .tally      (tally),
        .was_new    (was_new),
        .evicted    (evicted),
        .evicted_id (evicted_id),
        .fill       (fill)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic tally_result_t tally_occurrence(input logic [ID_BITS-1:0] id);
        tally_result_t         res;
        int                    pos;
        int                    slot;
        logic [COUNT_BITS-1:0] cnt;
        res = '0;
        pos = -1;
        for (int i = 0; i < list_used; i++)
        begin
            if (pos < 0 && list_ids[i] == id)
                pos = i;
        end
        if (pos >= 0)
        begin
            cnt = list_counts[pos];
            if (cnt != '1)
                cnt++;
            slot = pos;
            while (slot > 0 && list_counts[slot-1] < cnt)
            begin
                list_ids[slot]    = list_ids[slot-1];
                list_counts[slot] = list_counts[slot-1];
                slot--;
            end
        end
        else
        begin
            cnt = COUNT_BITS'(1);
            res.was_new = 1'b1;
            if (list_used >= LIST_DEPTH)
            begin
                slot = LIST_DEPTH - 1;
                res.evicted    = 1'b1;
                res.evicted_id = list_ids[slot];
            end
            else
            begin
                slot = list_used;
                list_used++;
            end
        end
        list_ids[slot]    = id;
        list_counts[slot] = cnt;
        res.rank  = RANK_W'(slot);
        res.tally = cnt;
        res.fill  = FILL_W'(list_used);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string describe(input tally_result_t r);
        return $sformatf("rank=%0d tally=%0d new=%0b evicted=%0b evicted_id=%05h fill=%0d",
                         r.rank, r.tally, r.was_new, r.evicted, r.evicted_id, r.fill);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic send_item(input logic [ID_BITS-1:0] id);
        int            gap;
        tally_result_t want;
        gap = idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        item_id  <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = tally_occurrence(id);
        expected_tallies.insert(expected_tallies.size(), want);
    endtask

    // fill with distinct ids, then climb from the last place to the top
    task automatic test_fill_and_climb();
        logic [ID_BITS-1:0] ids[11];
        ids = '{20'h00000, 20'hFFFFF, 20'h55555, 20'hAAAAA, 20'h00001, 20'h80000,
                20'h7FFFF, 20'h12345, 20'hFEDCB, 20'h00F0F, 20'hF0F0F};
        idle_on = 1'b0;
        foreach (ids[i])
            send_item(ids[i]);
        send_item(20'hF0F0F);
        send_item(20'h00000);
        send_item(20'hFFFFF);
        send_item(20'h00F0F);
    endtask

    task automatic test_eviction();
        idle_on = 1'b1;
        send_item(20'h3C3C3);
        send_item(20'hC3C3C);
        send_item(20'hC3C3C);
        send_item(20'h3C3C3);
        send_item(20'hFEDCB);
    endtask

    task automatic test_random_mix(input int count, input bit with_idle);
        int                 r;
        int                 a;
        int                 b;
        logic [ID_BITS-1:0] id;
        idle_on = with_idle;
        foreach (hot_ids[i])
            hot_ids[i] = ID_BITS'($urandom);
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                a  = $urandom_range(0, HOT_IDS - 1);
                b  = $urandom_range(0, HOT_IDS - 1);
                id = hot_ids[(a < b) ? a : b];
            end
            else if (r < 85 && list_used > 0)
                id = list_ids[$urandom_range(0, list_used - 1)];
            else
                id = ID_BITS'($urandom);
            send_item(id);
        end
    endtask

    // hammer one id, then disturb the list below it
    task automatic test_repeated_hits();
        idle_on = 1'b0;
        repeat (40)
            send_item(20'h5A5A5);
        idle_on = 1'b1;
        send_item(20'hA5A5A);
        send_item(20'h5A5A5);
        send_item(20'hA5A5A);
        send_item(ID_BITS'($urandom));
    endtask

    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!idle_on)
                out_ready <= 1'b1;
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        tally_result_t got;
        tally_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.rank       = rank;
            got.tally      = tally;
            got.was_new    = was_new;
            got.evicted    = evicted;
            got.evicted_id = evicted_id;
            got.fill       = fill;
            if (expected_tallies.size() == 0)
                log_mismatch({"unexpected transaction: ", describe(got)});
            else
            begin
                want = expected_tallies.pop_front();
                if (got !== want)
                    log_mismatch({"expected ", describe(want), " got ", describe(got)});
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        item_id  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_fill_and_climb();
        test_eviction();
        test_random_mix(425, 1'b1);
        test_random_mix(425, 1'b0);
        test_random_mix(425, 1'b1);
        test_random_mix(425, 1'b1);
        test_repeated_hits();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (2 * LIST_DEPTH) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tkot_pkg.sv
rtl/tkot_cell.sv
rtl/top_k_occurrence_tracker_core.sv
tb/sv/tb_top_k_occurrence_tracker_core.sv
